/* rtl/deq_pkg.sv */
`timescale 1ns / 1ps
// Shared types for the double-ended queue: operation codes, status codes,
// controller states and the command/status bundles between control and datapath.
package deq_pkg;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_LIST       = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // Source of the value loaded into the result register
  typedef enum logic [1:0] {
    SRC_OK_ZERO = 2'd0,
    SRC_EMPTY   = 2'd1,
    SRC_FULL    = 2'd2,
    SRC_RAM     = 2'd3
  } res_src_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_RESULT,
    S_LIST_FETCH,
    S_LIST_RESULT
  } state_e;

  typedef struct packed {
    logic     wr_front;    // push at front: step front back, write there
    logic     wr_back;     // push at back: write behind the last entry
    logic     rd_front;    // pop front: read front, advance front
    logic     rd_back;     // pop back: read last entry
    logic     list_first;  // start a listing at the front
    logic     list_next;   // step the listing offset and read
    logic     res_load;    // load the result register
    res_src_e res_src;
    logic     res_list;    // last flag comes from the listing offset
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;            // last flag of the held result
  } stat_t;

endpackage

/* rtl/deq_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/deq_dpath.sv */
`timescale 1ns / 1ps
// Datapath: front pointer, entry count, listing offset, slot RAM and result register.
// Depends on deq_pkg and deq_ram.
module deq_dpath #(
  parameter int CAPACITY = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [31:0]  value_i,
  input  deq_pkg::cmd_t       cmd_i,
  output deq_pkg::stat_t      stat_o,
  output logic [1:0]          status_o,
  output logic signed [31:0]  entry_o,
  output logic                last_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W:0]   CAP_EXT = (IDX_W + 1)'(CAPACITY);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [1:0]       STATUS_OK_C = 2'(deq_pkg::STATUS_OK);

  // Slot that lies off positions after base, wrapped at the capacity
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= CAP_EXT) begin
      sum = sum - CAP_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [IDX_W-1:0] front_d, front_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic [IDX_W-1:0] off_d, off_q;
  logic [1:0]       status_d, status_q;
  logic [31:0]      entry_d, entry_q;
  logic             last_d, last_q;

  logic [IDX_W-1:0] front_dec;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] off_p1;
  logic [CNT_W-1:0] off_ext_p1;
  logic             list_last;
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [31:0]      rd_data;

  assign front_dec  = (front_q == '0) ? LAST_IDX : front_q - IDX_W'(1);
  assign count_m1   = count_q - CNT_W'(1);
  assign off_p1     = off_q + IDX_W'(1);
  assign off_ext_p1 = CNT_W'(off_q) + CNT_W'(1);
  assign list_last  = (off_ext_p1 == count_q);

  assign wr_en   = cmd_i.wr_front | cmd_i.wr_back;
  assign wr_addr = cmd_i.wr_front ? front_dec : ring_pos(front_q, count_q[IDX_W-1:0]);
  assign rd_en   = cmd_i.rd_front | cmd_i.rd_back | cmd_i.list_first | cmd_i.list_next;

  always_comb begin
    priority if (cmd_i.rd_back) begin
      rd_addr = ring_pos(front_q, count_m1[IDX_W-1:0]);
    end else if (cmd_i.list_next) begin
      rd_addr = ring_pos(front_q, off_p1);
    end else begin
      rd_addr = front_q;
    end
  end

  deq_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(value_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    off_d   = off_q;
    if (cmd_i.wr_front) begin
      front_d = front_dec;
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.wr_back) begin
      count_d = count_q + CNT_W'(1);
    end
    if (cmd_i.rd_front) begin
      front_d = ring_pos(front_q, IDX_W'(1));
      count_d = count_m1;
    end
    if (cmd_i.rd_back) begin
      count_d = count_m1;
    end
    if (cmd_i.list_first) begin
      off_d = '0;
    end
    if (cmd_i.list_next) begin
      off_d = off_p1;
    end
  end

  always_comb begin
    status_d = STATUS_OK_C;
    entry_d  = '0;
    last_d   = 1'b1;
    unique case (cmd_i.res_src)
      deq_pkg::SRC_OK_ZERO: status_d = 2'(deq_pkg::STATUS_OK);
      deq_pkg::SRC_EMPTY:   status_d = 2'(deq_pkg::STATUS_EMPTY);
      deq_pkg::SRC_FULL:    status_d = 2'(deq_pkg::STATUS_FULL);
      deq_pkg::SRC_RAM: begin
        status_d = 2'(deq_pkg::STATUS_OK);
        entry_d  = rd_data;
        last_d   = cmd_i.res_list ? list_last : 1'b1;
      end
      default: status_d = 2'(deq_pkg::STATUS_OK);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      off_q   <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      off_q   <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      status_q <= status_d;
      entry_q  <= entry_d;
      last_q   <= last_d;
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CAP_CNT);
  assign stat_o.last  = last_q;

  assign status_o = status_q;
  assign entry_o  = entry_q;
  assign last_o   = last_q;

endmodule

/* rtl/deq_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences push, pop and listing over the datapath, owns both handshakes.
// Depends on deq_pkg.
module deq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [2:0]     kind_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  deq_pkg::stat_t stat_i,
  output deq_pkg::cmd_t  cmd_o
);

  deq_pkg::state_e state_d, state_q;
  deq_pkg::kind_e  kind;

  assign kind = deq_pkg::kind_e'(kind_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (kind)
            deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: state_d = deq_pkg::S_RESULT;
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
              state_d = stat_i.empty ? deq_pkg::S_RESULT : deq_pkg::S_FETCH;
            end
            deq_pkg::KIND_LIST: begin
              state_d = stat_i.empty ? deq_pkg::S_RESULT : deq_pkg::S_LIST_FETCH;
            end
            default: state_d = deq_pkg::S_IDLE;  // drop unknown operations
          endcase
        end
      end
      deq_pkg::S_FETCH:      state_d = deq_pkg::S_RESULT;
      deq_pkg::S_LIST_FETCH: state_d = deq_pkg::S_LIST_RESULT;
      deq_pkg::S_RESULT: begin
        if (out_ready_i) begin
          state_d = deq_pkg::S_IDLE;
        end
      end
      deq_pkg::S_LIST_RESULT: begin
        if (out_ready_i) begin
          state_d = stat_i.last ? deq_pkg::S_IDLE : deq_pkg::S_LIST_FETCH;
        end
      end
      default: state_d = deq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.res_src = deq_pkg::SRC_OK_ZERO;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      deq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (kind)
            deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
              cmd_o.res_load = 1'b1;
              if (stat_i.full) begin
                cmd_o.res_src = deq_pkg::SRC_FULL;
              end else begin
                cmd_o.wr_front = (kind == deq_pkg::KIND_PUSH_FRONT);
                cmd_o.wr_back  = (kind == deq_pkg::KIND_PUSH_BACK);
              end
            end
            deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
              if (stat_i.empty) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_src  = deq_pkg::SRC_EMPTY;
              end else begin
                cmd_o.rd_front = (kind == deq_pkg::KIND_POP_FRONT);
                cmd_o.rd_back  = (kind == deq_pkg::KIND_POP_BACK);
              end
            end
            deq_pkg::KIND_LIST: begin
              if (stat_i.empty) begin
                cmd_o.res_load = 1'b1;
                cmd_o.res_src  = deq_pkg::SRC_EMPTY;
              end else begin
                cmd_o.list_first = 1'b1;
              end
            end
            default: cmd_o.res_load = 1'b0;
          endcase
        end
      end
      deq_pkg::S_FETCH: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_src  = deq_pkg::SRC_RAM;
      end
      deq_pkg::S_LIST_FETCH: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_src  = deq_pkg::SRC_RAM;
        cmd_o.res_list = 1'b1;
      end
      deq_pkg::S_RESULT: begin
        out_valid_o = 1'b1;
      end
      deq_pkg::S_LIST_RESULT: begin
        out_valid_o = 1'b1;
        // advance to the next entry once this beat is taken
        cmd_o.list_next = out_ready_i & ~stat_i.last;
      end
      default: out_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= deq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/double_ended_queue_core.sv */
`timescale 1ns / 1ps
// Double-ended queue of signed 32-bit values, CAPACITY entries in a circular slot RAM.
// Depends on deq_pkg, deq_ctrl, deq_dpath and deq_ram.
//
// One operation is in flight at a time. A push, or any operation that finds the
// store full or empty, passes through accept and result beat; a pop passes through
// accept, RAM read and result beat; a listing of N entries passes through accept
// and then a RAM read and a result beat for each entry.
// This sequence follows from the single registered read port of the slot RAM and
// the single result register. Unknown operation codes are accepted and dropped
// with no result. Slots need no clearing after reset.
module double_ended_queue_core #(
  parameter int CAPACITY = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] entry_o,
  output logic               last_o
);

  deq_pkg::cmd_t  cmd;
  deq_pkg::stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  deq_dpath #(
    .CAPACITY(CAPACITY)
  ) u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .value_i (value_i),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .status_o(status_o),
    .entry_o (entry_o),
    .last_o  (last_o)
  );

endmodule

/* tb/sv/double_ended_queue_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for double_ended_queue_core: directed table, then random phases.
// Depends on deq_pkg and the RTL of double_ended_queue_core; predicts with its own ring model.
module double_ended_queue_core_tb;

  localparam int CAP          = 32;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RAND_ITEMS   = 320;
  localparam int QUIET_AFTER  = 260;
  localparam int LONG_HOLD    = 160;
  localparam int TAIL_CYCLES  = 80;
  localparam int NUM_ROWS     = 22;

  // operation codes the block accepts and drops
  localparam logic [2:0] KIND_RSVD_LO  = 3'd5;
  localparam logic [2:0] KIND_RSVD_MID = 3'd6;
  localparam logic [2:0] KIND_RSVD_HI  = 3'd7;

  typedef struct packed {
    deq_pkg::status_e   status;
    logic signed [31:0] entry;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic               typed;
    deq_pkg::status_e   st;
    logic signed [31:0] ent;
  } row_t;

  typedef enum logic [2:0] {
    PH_MIXED,
    PH_GROW,
    PH_SHRINK,
    PH_TO_FULL,
    PH_TO_EMPTY
  } phase_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         kind_i;
  logic signed [31:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic signed [31:0] entry_o;
  logic               last_o;

  // ring model of the store
  logic signed [31:0] deque_ring [CAP];
  int unsigned        deque_head;
  int unsigned        deque_fill;

  beat_t model_beats[$];
  beat_t expected_beats[$];

  int  err_count   = 0;
  int  cycle_count = 0;
  int  rand_items  = 0;
  bit  quiet       = 1'b0;
  bit  hold_off_req  = 1'b0;
  bit  hold_off_done = 1'b0;

  row_t dir_rows [NUM_ROWS];

  double_ended_queue_core #(
    .CAPACITY(CAP)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .entry_o    (entry_o),
    .last_o     (last_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void add_beat(deq_pkg::status_e st, logic signed [31:0] ent, logic lst);
    beat_t b;
    b.status = st;
    b.entry  = ent;
    b.last   = lst;
    model_beats.push_back(b);
  endfunction

  // Apply one operation to the ring model and collect the beats it produces.
  function automatic void apply_deque_op(logic [2:0] kind, logic signed [31:0] val);
    logic signed [31:0] v;
    model_beats.delete();
    case (kind)
      deq_pkg::KIND_PUSH_FRONT, deq_pkg::KIND_PUSH_BACK: begin
        if (deque_fill == CAP) begin
          add_beat(deq_pkg::STATUS_FULL, '0, 1'b1);
        end else begin
          if (kind == deq_pkg::KIND_PUSH_FRONT) begin
            deque_head = (deque_head + CAP - 1) % CAP;
            deque_ring[deque_head] = val;
          end else begin
            deque_ring[(deque_head + deque_fill) % CAP] = val;
          end
          deque_fill++;
          add_beat(deq_pkg::STATUS_OK, '0, 1'b1);
        end
      end
      deq_pkg::KIND_POP_FRONT, deq_pkg::KIND_POP_BACK: begin
        if (deque_fill == 0) begin
          add_beat(deq_pkg::STATUS_EMPTY, '0, 1'b1);
        end else begin
          if (kind == deq_pkg::KIND_POP_FRONT) begin
            v = deque_ring[deque_head];
            deque_head = (deque_head + 1) % CAP;
          end else begin
            v = deque_ring[(deque_head + deque_fill - 1) % CAP];
          end
          deque_fill--;
          add_beat(deq_pkg::STATUS_OK, v, 1'b1);
        end
      end
      deq_pkg::KIND_LIST: begin
        if (deque_fill == 0) begin
          add_beat(deq_pkg::STATUS_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < deque_fill; i++) begin
            add_beat(deq_pkg::STATUS_OK, deque_ring[(deque_head + i) % CAP],
                     i == deque_fill - 1);
          end
        end
      end
      default: ;  // dropped, no beat
    endcase
  endfunction

  // Offer one item, hold it until accepted, then log what it must produce.
  task automatic issue_op(logic [2:0] kind, logic signed [31:0] val, logic typed,
                          deq_pkg::status_e st, logic signed [31:0] ent);
    beat_t b;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    apply_deque_op(kind, val);
    if (typed) begin
      b.status = st;
      b.entry  = ent;
      b.last   = 1'b1;
      expected_beats.push_back(b);
    end else begin
      foreach (model_beats[i]) expected_beats.push_back(model_beats[i]);
    end
    if (kind <= deq_pkg::KIND_LIST) rand_items++;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Pick an operation code; push_pct biases pushes against pops.
  function automatic logic [2:0] pick_kind(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      case ($urandom_range(0, 2))
        0:       return KIND_RSVD_LO;
        1:       return KIND_RSVD_MID;
        default: return KIND_RSVD_HI;
      endcase
    end
    if (r < 11) return deq_pkg::KIND_LIST;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_BACK;
    return $urandom_range(0, 1) ? deq_pkg::KIND_POP_FRONT : deq_pkg::KIND_POP_BACK;
  endfunction

  function automatic logic [2:0] any_push();
    return $urandom_range(0, 1) ? deq_pkg::KIND_PUSH_FRONT : deq_pkg::KIND_PUSH_BACK;
  endfunction

  function automatic logic [2:0] any_pop();
    return $urandom_range(0, 1) ? deq_pkg::KIND_POP_FRONT : deq_pkg::KIND_POP_BACK;
  endfunction

  // Compare every accepted result beat against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    beat_t exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        err_count++;
        $display("%0t: unexpected beat, expected none, actual status %0d entry %0d last %0d",
                 $time, status_o, entry_o, last_o);
      end else begin
        exp_b = expected_beats.pop_front();
        if (status_o !== exp_b.status) begin
          err_count++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, exp_b.status, status_o);
        end
        if (entry_o !== exp_b.entry) begin
          err_count++;
          $display("%0t: entry mismatch, expected %0d actual %0d",
                   $time, exp_b.entry, entry_o);
        end
        if (last_o !== exp_b.last) begin
          err_count++;
          $display("%0t: last mismatch, expected %0d actual %0d",
                   $time, exp_b.last, last_o);
        end
      end
    end
  end

  // Result side: short random stalls, one long hold-off on request.
  initial begin : result_side
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_ready_i <= 1'b0;
        for (int n = 1; n < LONG_HOLD; n++) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    phase_e ph;
    int     span;
    int     bias;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    kind_i     = deq_pkg::KIND_PUSH_FRONT;
    value_i    = '0;
    deque_head = 0;
    deque_fill = 0;

    dir_rows = '{
      '{deq_pkg::KIND_POP_FRONT,  32'sd0,         1'b1, deq_pkg::STATUS_EMPTY, 32'sd0},
      '{deq_pkg::KIND_POP_BACK,   32'sd0,         1'b1, deq_pkg::STATUS_EMPTY, 32'sd0},
      '{deq_pkg::KIND_LIST,       32'sd0,         1'b1, deq_pkg::STATUS_EMPTY, 32'sd0},
      '{KIND_RSVD_LO,             32'sh1234_5678, 1'b0, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_PUSH_FRONT, 32'sh7FFF_FFFF, 1'b1, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_POP_BACK,   32'sd0,         1'b1, deq_pkg::STATUS_OK,    32'sh7FFF_FFFF},
      '{deq_pkg::KIND_PUSH_BACK,  32'sh8000_0000, 1'b1, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_POP_FRONT,  32'sd0,         1'b1, deq_pkg::STATUS_OK,    32'sh8000_0000},
      '{KIND_RSVD_MID,            -32'sd1,        1'b0, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_PUSH_BACK,  -32'sd1,        1'b1, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_PUSH_FRONT, 32'sd0,         1'b1, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_PUSH_BACK,  32'sh5555_5555, 1'b1, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_PUSH_FRONT, 32'shAAAA_AAAA, 1'b1, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_LIST,       32'sd0,         1'b0, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_POP_BACK,   32'sd0,         1'b0, deq_pkg::STATUS_OK,    32'sd0},
      '{KIND_RSVD_HI,             32'sh7FFF_FFFF, 1'b0, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_POP_FRONT,  32'sd0,         1'b0, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_LIST,       32'sd0,         1'b0, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_POP_FRONT,  32'sd0,         1'b0, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_POP_BACK,   32'sd0,         1'b0, deq_pkg::STATUS_OK,    32'sd0},
      '{deq_pkg::KIND_POP_BACK,   32'sd0,         1'b1, deq_pkg::STATUS_EMPTY, 32'sd0},
      '{deq_pkg::KIND_LIST,       32'sd0,         1'b1, deq_pkg::STATUS_EMPTY, 32'sd0}
    };

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r])
      issue_op(dir_rows[r].kind, dir_rows[r].value, dir_rows[r].typed,
               dir_rows[r].st, dir_rows[r].ent);

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      quiet = (rand_items >= QUIET_AFTER);
      ph = phase_e'($urandom_range(0, 4));
      if (!hold_off_req && rand_items >= 80) begin
        // stall the result side while the sender keeps offering
        hold_off_req = 1'b1;
        ph = PH_TO_FULL;
      end
      case (ph)
        PH_TO_FULL, PH_TO_EMPTY: begin
          while (ph == PH_TO_FULL ? deque_fill < CAP : deque_fill > 0)
            issue_op(ph == PH_TO_FULL ? any_push() : any_pop(), pick_value(),
                     1'b0, deq_pkg::STATUS_OK, '0);
          // overrun the boundary, then list
          repeat (2)
            issue_op(ph == PH_TO_FULL ? any_push() : any_pop(), pick_value(),
                     1'b0, deq_pkg::STATUS_OK, '0);
          issue_op(deq_pkg::KIND_LIST, pick_value(), 1'b0, deq_pkg::STATUS_OK, '0);
        end
        default: begin
          bias = (ph == PH_GROW) ? 85 : (ph == PH_SHRINK) ? 15 : 50;
          span = $urandom_range(10, 45);
          repeat (span)
            issue_op(pick_kind(bias), pick_value(), 1'b0, deq_pkg::STATUS_OK, '0);
        end
      endcase
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    quiet = 1'b1;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
